@@ rtl/core/flg_pkg.sv @@
`timescale 1ns / 1ps

package flg_pkg;

    localparam int DELAY_DEPTH = 1024;
    localparam int LFO_DEPTH   = 1024;
    localparam int DLY_AW      = $clog2(DELAY_DEPTH);
    localparam int LFO_AW      = $clog2(LFO_DEPTH);

    localparam int SAMPLE_W  = 16;
    localparam int BASE_W    = 10;
    localparam int DEPTH_W   = 16;
    localparam int GAIN_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IW    = 2;
    localparam int MUL_W     = 17;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int DSUM_W    = 19;

    localparam logic [CFG_IW-1:0] REG_BASE_DELAY = 2'd0;
    localparam logic [CFG_IW-1:0] REG_MOD_DEPTH  = 2'd1;
    localparam logic [CFG_IW-1:0] REG_MIX_GAIN   = 2'd2;

    localparam logic [BASE_W-1:0]         BASE_DELAY_RST = 10'd512;
    localparam logic [DEPTH_W-1:0]        MOD_DEPTH_RST  = 16'd256;
    localparam logic signed [GAIN_W-1:0]  MIX_GAIN_RST   = 16'sd22938;

    localparam logic [63:0] HALFPI_Q61 = 64'h3243F6A8885A308D;
    localparam logic [63:0] LO32       = 64'h00000000FFFFFFFF;
    localparam logic [63:0] HALFPI_STEP = HALFPI_Q61 / 64'(LFO_DEPTH);
    localparam logic [63:0] HALFPI_REM  = HALFPI_Q61 % 64'(LFO_DEPTH);

    typedef logic signed [SAMPLE_W-1:0] sine_tab_t [LFO_DEPTH];

    typedef struct packed {
        logic                    wr_en;
        logic [DLY_AW-1:0]       wr_addr;
        logic [SAMPLE_W-1:0]     wr_data;
        logic                    rd_en;
        logic [DLY_AW-1:0]       rd_addr;
    } ram_req_t;

    // floor(a*b / 2^61), low 64 bits
    function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[124:61];
    endfunction

    // floor(n / d), long division for table building
    function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // trunc(32767 * sin(m*pi/(2*LFO_DEPTH))) for 0 < m < LFO_DEPTH
    function automatic logic signed [SAMPLE_W-1:0] quarter_sine(input logic [63:0] m);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] t;
        x = HALFPI_STEP * m + ((HALFPI_REM * m) >> LFO_AW);
        x2   = mul_q61(x, x);
        term = x;
        sum  = x;
        for (int k = 1; k < 40; k++) begin
            if (term != 64'd0) begin
                term = div_u64(mul_q61(term, x2), 64'(2 * k) * 64'(2 * k + 1));
                if (k % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
        end
        hi = sum >> 32;
        lo = sum & LO32;
        t  = 64'd32767 * hi + ((64'd32767 * lo) >> 32);
        return SAMPLE_W'(t >> 29);
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t          tab;
        logic [63:0]        num;
        logic [63:0]        q;
        logic [63:0]        r;
        logic [63:0]        m;
        logic signed [SAMPLE_W-1:0] v;
        for (int i = 0; i < LFO_DEPTH; i++) begin
            num = 64'(4 * i);
            q   = num / 64'(LFO_DEPTH);
            r   = num % 64'(LFO_DEPTH);
            if (r == 64'd0) begin
                if (q == 64'd1)
                    v = 16'sd32767;
                else if (q == 64'd3)
                    v = -16'sd32767;
                else
                    v = 16'sd0;
            end else begin
                m = q[0] ? (64'(LFO_DEPTH) - r) : r;
                v = quarter_sine(m);
                if (q >= 64'd2)
                    v = -v;
            end
            tab[i] = v;
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

@@ rtl/core/flg_if.sv @@
`timescale 1ns / 1ps

interface flg_in_if import flg_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic                       block_last;

    modport source (output valid, output in_sample, output block_last, input ready);
    modport sink   (input valid, input in_sample, input block_last, output ready);
endinterface

interface flg_out_if import flg_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       out_last;

    modport source (output valid, output out_sample, output out_last, input ready);
    modport sink   (input valid, input out_sample, input out_last, output ready);
endinterface

@@ rtl/core/flg_sine_rom.sv @@
`timescale 1ns / 1ps

module flg_sine_rom import flg_pkg::*;
(
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [LFO_AW-1:0]          addr,
    output logic signed [SAMPLE_W-1:0] data
);

    logic signed [SAMPLE_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_reg <= SINE_TAB[addr];
        end
    end

    assign data = data_reg;

endmodule

@@ rtl/core/flg_delay_ram.sv @@
`timescale 1ns / 1ps

module flg_delay_ram import flg_pkg::*;
(
    input  logic                clk,
    input  ram_req_t            req,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] mem [DELAY_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/flg_mul.sv @@
`timescale 1ns / 1ps

module flg_mul import flg_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

@@ rtl/core/sine_lfo_flanger_core.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Payload                                  Transfer
// audio     in   in_sample[15:0] s, block_last            valid & ready
// flanged   out  out_sample[15:0] s, out_last             valid & ready
// cfg       in   cfg_index[1:0], cfg_data[15:0]           cfg_wr_en
//
// Steps for each accepted sample, in order: sine ROM read, depth*LFO on
// the shared 17x17 multiplier, delay line read/write, gain*delayed on the same
// multiplier; the result loads the output register as the next sample is taken.
// A stalled output holds the sequencer in its last step; audio.ready stays low.
// Reset clears pointers and the fill flag; unfilled delay entries read as zero.

module sine_lfo_flanger_core import flg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    flg_in_if.sink            audio,
    flg_out_if.source         flanged,
    input  logic              cfg_wr_en,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LFO  = 5'b00010,
        ST_ADDR = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    localparam logic signed [DSUM_W-1:0] DLY_MAX = DSUM_W'(DELAY_DEPTH - 1);
    localparam logic signed [DSUM_W-1:0] DLY_MIN = DSUM_W'(1);

    state_t state_reg, state_next;

    logic [BASE_W-1:0]         base_delay_reg;
    logic [DEPTH_W-1:0]        mod_depth_reg;
    logic signed [GAIN_W-1:0]  mix_gain_reg;

    logic [LFO_AW-1:0]         phase_reg, phase_next;
    logic [DLY_AW-1:0]         wp_reg, wp_next;
    logic                      filled_reg, filled_next;
    logic                      out_valid_reg, out_valid_next;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       last_reg;
    logic                       rd_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_last_reg;

    logic                       in_fire;
    logic                       out_free;
    logic                       out_load;

    logic signed [SAMPLE_W-1:0] lfo;
    logic [SAMPLE_W-1:0]        delayed;
    logic                       mul_en;
    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   prod;

    logic signed [DSUM_W-1:0]   dly_sum;
    logic [DLY_AW-1:0]          dly;
    logic [DLY_AW:0]            rd_diff;
    logic [DLY_AW-1:0]          rd_addr;
    logic                       rd_valid;
    logic signed [SAMPLE_W-1:0] y;
    ram_req_t                   ram_req;

    assign out_free = !out_valid_reg || flanged.ready;
    assign out_load = (state_reg == ST_DONE) && out_free;
    assign audio.ready = (state_reg == ST_IDLE) || out_load;
    assign in_fire = audio.valid && audio.ready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_delay_reg <= BASE_DELAY_RST;
            mod_depth_reg  <= MOD_DEPTH_RST;
            mix_gain_reg   <= MIX_GAIN_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BASE_DELAY: base_delay_reg <= cfg_data[BASE_W-1:0];
                REG_MOD_DEPTH:  mod_depth_reg  <= cfg_data[DEPTH_W-1:0];
                REG_MIX_GAIN:   mix_gain_reg   <= cfg_data[GAIN_W-1:0];
                default:        ;
            endcase
        end
    end

    // delay computation
    always_comb
    begin
        dly_sum = DSUM_W'($signed({1'b0, base_delay_reg}))
                  + DSUM_W'($signed(prod[PROD_W-1:16]));
        if (dly_sum < DLY_MIN)
            dly = DLY_AW'(1);
        else if (dly_sum > DLY_MAX)
            dly = DLY_AW'(DELAY_DEPTH - 1);
        else
            dly = dly_sum[DLY_AW-1:0];
        rd_diff = {1'b0, wp_reg} - {1'b0, dly};
        if (rd_diff[DLY_AW])
            rd_addr = DLY_AW'(rd_diff + (DLY_AW + 1)'(DELAY_DEPTH));
        else
            rd_addr = rd_diff[DLY_AW-1:0];
        rd_valid = filled_reg || (rd_addr < wp_reg);
    end

    assign ram_req.wr_en   = (state_reg == ST_ADDR);
    assign ram_req.wr_addr = wp_reg;
    assign ram_req.wr_data = sample_reg;
    assign ram_req.rd_en   = (state_reg == ST_ADDR);
    assign ram_req.rd_addr = rd_addr;

    // shared multiplier operands
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        if (state_reg == ST_LFO)
        begin
            mul_en = 1'b1;
            mul_a  = $signed({1'b0, mod_depth_reg});
            mul_b  = MUL_W'(lfo);
        end
        else if (state_reg == ST_MUL)
        begin
            mul_en = 1'b1;
            mul_a  = MUL_W'(mix_gain_reg);
            mul_b  = rd_valid_reg ? MUL_W'($signed(delayed)) : '0;
        end
    end

    assign y = sample_reg + $signed(prod[SAMPLE_W+14:15]);

    // sequencer and pointers
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        wp_next        = wp_reg;
        filled_next    = filled_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && flanged.ready)
            out_valid_next = 1'b0;
        if (in_fire)
        begin
            if (phase_reg == LFO_AW'(LFO_DEPTH - 1))
                phase_next = '0;
            else
                phase_next = phase_reg + 1'b1;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_LFO;
            end
            ST_LFO:
            begin
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                state_next = ST_MUL;
                if (wp_reg == DLY_AW'(DELAY_DEPTH - 1))
                begin
                    wp_next     = '0;
                    filled_next = 1'b1;
                end
                else
                begin
                    wp_next = wp_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = in_fire ? ST_LFO : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            wp_reg        <= '0;
            filled_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            wp_reg        <= wp_next;
            filled_reg    <= filled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg <= audio.in_sample;
            last_reg   <= audio.block_last;
        end
        if (state_reg == ST_ADDR)
        begin
            rd_valid_reg <= rd_valid;
        end
        if (out_load)
        begin
            out_sample_reg <= y;
            out_last_reg   <= last_reg;
        end
    end

    assign flanged.valid      = out_valid_reg;
    assign flanged.out_sample = out_sample_reg;
    assign flanged.out_last   = out_last_reg;

    flg_sine_rom u_rom
    (
        .clk   (clk),
        .rd_en (in_fire),
        .addr  (phase_reg),
        .data  (lfo)
    );

    flg_delay_ram u_ram
    (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (delayed)
    );

    flg_mul u_mul
    (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    a_rd_not_wp : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ADDR |-> rd_addr != wp_reg)
        else $error("delay read hits the write slot");

    a_fire_starts : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == ST_LFO)
        else $error("accepted sample did not start the sequence");

    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || flanged.ready))
        else $error("pending result overwritten");

    a_wp_step : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_ADDR |=> $stable(wp_reg))
        else $error("write pointer moved outside the write step");

endmodule
